// ===== sv/gmpd_pkg.sv =====
// Shared types, constants and normal tables for the mixture density block.
package gmpd_pkg;

    localparam int MAX_COMPONENTS     = 8;
    localparam int NORMAL_TABLE_DEPTH = 1024;
    localparam int Z_OFFSET           = 512;
    localparam int K_LIMIT            = 1024;
    localparam int TAYLOR_TERMS       = 24;
    localparam int IDX_W              = $clog2(NORMAL_TABLE_DEPTH);
    localparam int SLOT_W             = $clog2(MAX_COMPONENTS);
    localparam int ACC_W              = 51;
    localparam int DIV_STEPS          = 33;
    localparam int DIV_CNT_W          = 6;

    localparam longint unsigned Q31_ONE          = 64'd2147483648;
    localparam longint unsigned INV_SQRT_2PI_Q31 = 64'd856722024;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PDF  = 2'd1,
        OP_CDF  = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DONE
    } state_t;

    // item riding down the cell chain
    typedef struct packed {
        op_t                op;
        logic signed [31:0] x;
        logic [ACC_W-1:0]   sum;
    } chain_t;

    // component write broadcast to the cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       mean;
        logic [31:0]       inv_sd;
        logic [16:0]       weight;
    } load_t;

    typedef logic [31:0] tab_t [NORMAL_TABLE_DEPTH];

    // floor(num / den) by shift and subtract, den nonzero; table build only
    function automatic longint unsigned udiv_q(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        if (num < den) return 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // exp(-x / 2^31) in Q1.31
    function automatic longint unsigned exp_neg_q31(longint unsigned x);
        longint          sum;
        longint unsigned term;
        sum  = longint'(Q31_ONE);
        term = Q31_ONE;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = (term * x) >> 31;
            term = udiv_q(term, 64'(n));
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        return (sum < 0) ? 64'd0 : longint'(sum);
    endfunction

    // phi(k / 128) in Q1.31
    function automatic longint unsigned phi_half_step(longint k);
        longint          ka;
        longint unsigned m;
        longint unsigned q;
        longint unsigned e;
        longint unsigned e1;
        ka = (k < 0) ? -k : k;
        if (ka > K_LIMIT) return 64'd0;
        m  = longint'(ka) * longint'(ka);
        q  = m >> 15;
        e  = exp_neg_q31((m & 64'd32767) << 16);
        e1 = exp_neg_q31(Q31_ONE);
        for (longint unsigned j = 0; j < q; j++) begin
            e = (e * e1) >> 31;
        end
        return (e * INV_SQRT_2PI_Q31) >> 31;
    endfunction

    function automatic tab_t build_phi();
        tab_t            t;
        longint unsigned fa;
        for (int i = 0; i < NORMAL_TABLE_DEPTH; i++) begin
            fa   = phi_half_step(2 * longint'(i - Z_OFFSET));
            t[i] = 32'((fa + 64'd16384) >> 15);
        end
        return t;
    endfunction

    function automatic tab_t build_cum();
        tab_t            t;
        longint unsigned acc;
        longint          k;
        acc = 64'd0;
        for (int i = 0; i < NORMAL_TABLE_DEPTH; i++) begin
            k    = 2 * longint'(i - Z_OFFSET);
            t[i] = 32'(udiv_q(acc + 64'd384 * 64'd16384, 64'd384 * 64'd32768));
            acc  = acc + phi_half_step(k) + 64'd4 * phi_half_step(k + 1)
                 + phi_half_step(k + 2);
        end
        return t;
    endfunction

    localparam tab_t PHI_TAB = build_phi();
    localparam tab_t CUM_TAB = build_cum();

endpackage

// ===== sv/gmpd_div.sv =====
// Restoring divider producing floor(2^32 / sd), clamped to 32 bits.
module gmpd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] sd,
    output logic        done,
    output logic [31:0] inv_sd
);

    logic [30:0]                   den_reg, den_next;
    logic [30:0]                   rem_reg, rem_next;
    logic [32:0]                   quo_reg, quo_next;
    logic [gmpd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [31:0]                   shifted;
    logic                          fits;

    // dividend is 2^32: its only set bit enters on the first step
    assign shifted = {rem_reg, (cnt_reg == '0)};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            den_next  = (sd == '0) ? 31'd1 : sd;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 31'(shifted - {1'b0, den_reg}) : shifted[30:0];
            quo_next = {quo_reg[31:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gmpd_pkg::DIV_CNT_W'(gmpd_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done   = done_reg;
    assign inv_sd = quo_reg[32] ? 32'hFFFF_FFFF : quo_reg[31:0];

endmodule

// ===== sv/gmpd_cell.sv =====
// One mixture component: holds its parameters and adds its term to the passing sum.
module gmpd_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gmpd_pkg::SLOT_W-1:0]   cell_slot,
    input  logic                          cell_en,
    input  gmpd_pkg::load_t               load,
    input  logic                          in_valid,
    input  gmpd_pkg::chain_t              in_item,
    output logic                          out_valid,
    output gmpd_pkg::chain_t              out_item
);

    localparam int IW = gmpd_pkg::IDX_W;
    localparam logic [IW-1:0] Z_OFF = IW'(gmpd_pkg::Z_OFFSET);
    localparam logic [IW-1:0] I_MAX = IW'(gmpd_pkg::NORMAL_TABLE_DEPTH - 1);
    localparam logic [38:0] K_NEG_LIM = 39'(gmpd_pkg::Z_OFFSET);
    localparam logic [38:0] K_POS_LIM =
        39'(gmpd_pkg::NORMAL_TABLE_DEPTH - 1 - gmpd_pkg::Z_OFFSET);

    logic [31:0] mean_reg;
    logic [31:0] inv_reg;
    logic [16:0] wgt_reg;

    gmpd_pkg::chain_t pipe_reg [6];
    logic [6:0]       vld_reg;

    logic        neg1_reg, neg2_reg;
    logic [32:0] mag_reg;
    logic [47:0] pp_lo_reg;
    logic [48:0] pp_hi_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [31:0] tv_reg;
    logic [48:0] wt_reg, wt6_reg;
    logic [55:0] dlo_reg;
    logic [56:0] dhi_reg;
    gmpd_pkg::chain_t out_reg, out_next;

    logic signed [32:0] diff;
    logic [64:0]        prod, prod_up;
    logic [80:0]        dens_full;
    logic [gmpd_pkg::ACC_W-1:0] term;

    always_ff @(posedge aclk) begin
        if (load.en && load.slot == cell_slot) begin
            mean_reg <= load.mean;
            inv_reg  <= load.inv_sd;
            wgt_reg  <= load.weight;
        end
    end

    assign diff = {in_item.x[31], in_item.x} - {mean_reg[31], mean_reg};

    // z*64 index, floor rounding, clamped to the table
    assign prod    = {pp_hi_reg, 16'b0} + {17'b0, pp_lo_reg};
    assign prod_up = prod + 65'((65'd1 << 26) - 65'd1);

    always_comb begin
        if (neg2_reg) begin
            idx_next = (prod_up[64:26] >= K_NEG_LIM) ? '0 : Z_OFF - prod_up[IW+25:26];
        end else begin
            idx_next = (prod[64:26] >= K_POS_LIM) ? I_MAX : Z_OFF + prod[IW+25:26];
        end
    end

    assign dens_full = {dhi_reg, 24'b0} + {25'b0, dlo_reg};

    always_comb begin
        if (!cell_en) begin
            term = '0;
        end else if (pipe_reg[5].op == gmpd_pkg::OP_PDF) begin
            term = gmpd_pkg::ACC_W'(dens_full[80:16]);
        end else begin
            term = gmpd_pkg::ACC_W'(wt6_reg);
        end
        out_next     = pipe_reg[5];
        out_next.sum = pipe_reg[5].sum + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
        pipe_reg[0] <= in_item;
        for (int i = 1; i < 6; i++) pipe_reg[i] <= pipe_reg[i-1];
        neg1_reg  <= diff[32];
        mag_reg   <= diff[32] ? 33'(-diff) : 33'(diff);
        neg2_reg  <= neg1_reg;
        pp_lo_reg <= mag_reg[15:0] * inv_reg;
        pp_hi_reg <= mag_reg[32:16] * inv_reg;
        idx_reg   <= idx_next;
        tv_reg    <= (pipe_reg[2].op == gmpd_pkg::OP_CDF) ? gmpd_pkg::CUM_TAB[idx_reg]
                                                         : gmpd_pkg::PHI_TAB[idx_reg];
        wt_reg    <= tv_reg * wgt_reg;
        wt6_reg   <= wt_reg;
        dlo_reg   <= wt_reg[23:0] * inv_reg;
        dhi_reg   <= wt_reg[48:24] * inv_reg;
        out_reg   <= out_next;
    end

    assign out_valid = vld_reg[6];
    assign out_item  = out_reg;

endmodule

// ===== sv/gaussian_mixture_pdf_cdf.sv =====
// Top level of the Gaussian mixture density / cumulative probability block.
//
//  channel   | dir | payload
//  ----------+-----+---------------------------------------------------------
//  s_axis    | in  | tuser opcode; tdata x, slot, mean, sd, weight
//  m_axis    | out | tdata value; tuser saturated
//  cfg       | in  | component_count (4 bits), write-only
//
// An evaluate transaction walks a chain of eight component cells; the sum
// is registered in ST_RUN and loaded into the output register in ST_DONE,
// and no further item is accepted until the block is back in ST_IDLE.
// A load runs the 33-step reciprocal divider; not ready again until done.
// Reset (synchronous, active low) clears control; component slots stay
// undefined until loaded. A waiting result does not block accepting loads
// or the next evaluate, which parks in ST_DONE until the output frees.
module gaussian_mixture_pdf_cdf (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] sample_x, [34:32] component_index, [66:35] component_mean,
    // [97:67] component_sd, [114:98] component_weight, [119:115] zero
    input  logic [119:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] value
    output logic [31:0]  m_tdata,
    // [0] saturated
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data
);

    localparam int NC = gmpd_pkg::MAX_COMPONENTS;

    gmpd_pkg::state_t state_reg, state_next;

    logic [3:0]  count_reg;
    logic [gmpd_pkg::SLOT_W-1:0] slot_reg;
    logic [31:0] mean_reg;
    logic [16:0] wgt_reg;
    logic [gmpd_pkg::ACC_W-1:0] res_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg;
    logic        m_sat_reg;

    logic        accept;
    gmpd_pkg::op_t in_op;
    logic        div_start, div_done;
    logic [31:0] inv_sd;
    logic        inject, out_load;
    logic        load_en;

    gmpd_pkg::load_t  load;
    gmpd_pkg::chain_t chain  [NC+1];
    logic             chain_v[NC+1];

    logic [34:0] rounded;

    assign in_op  = gmpd_pkg::op_t'(s_tuser);
    assign accept = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gmpd_pkg::ST_IDLE: begin
                if (accept && in_op == gmpd_pkg::OP_LOAD) begin
                    state_next = gmpd_pkg::ST_DIV;
                end else if (accept && (in_op == gmpd_pkg::OP_PDF ||
                                        in_op == gmpd_pkg::OP_CDF)) begin
                    state_next = gmpd_pkg::ST_RUN;
                end
            end
            gmpd_pkg::ST_DIV: begin
                if (div_done) state_next = gmpd_pkg::ST_IDLE;
            end
            gmpd_pkg::ST_RUN: begin
                if (chain_v[NC]) state_next = gmpd_pkg::ST_DONE;
            end
            gmpd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) state_next = gmpd_pkg::ST_IDLE;
            end
            default: state_next = gmpd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        inject    = 1'b0;
        out_load  = 1'b0;
        load_en   = 1'b0;
        unique case (state_reg)
            gmpd_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = s_tvalid && in_op == gmpd_pkg::OP_LOAD;
                inject    = s_tvalid && (in_op == gmpd_pkg::OP_PDF ||
                                         in_op == gmpd_pkg::OP_CDF);
            end
            gmpd_pkg::ST_DIV:  load_en  = div_done;
            gmpd_pkg::ST_RUN:  ;
            gmpd_pkg::ST_DONE: out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign load.en     = load_en;
    assign load.slot   = slot_reg;
    assign load.mean   = mean_reg;
    assign load.inv_sd = inv_sd;
    assign load.weight = wgt_reg;

    gmpd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sd      (s_tdata[97:67]),
        .done    (div_done),
        .inv_sd  (inv_sd)
    );

    assign chain_v[0]   = inject;
    assign chain[0].op  = in_op;
    assign chain[0].x   = s_tdata[31:0];
    assign chain[0].sum = '0;

    for (genvar c = 0; c < NC; c++) begin : g_cell
        gmpd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_slot (gmpd_pkg::SLOT_W'(c)),
            .cell_en   (32'(count_reg) > c),
            .load      (load),
            .in_valid  (chain_v[c]),
            .in_item   (chain[c]),
            .out_valid (chain_v[c+1]),
            .out_item  (chain[c+1])
        );
    end

    // round half up to Q16.16 and clamp
    assign rounded = 35'((res_reg + gmpd_pkg::ACC_W'(32768)) >> 16);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load)      m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gmpd_pkg::ST_IDLE;
            count_reg   <= 4'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) count_reg <= cfg_wr_data;
        end
        if (div_start) begin
            slot_reg <= s_tdata[34:32];
            mean_reg <= s_tdata[66:35];
            wgt_reg  <= (s_tdata[114:98] > 17'd65536) ? 17'd65536 : s_tdata[114:98];
        end
        if (state_reg == gmpd_pkg::ST_RUN && chain_v[NC]) res_reg <= chain[NC].sum;
        if (out_load) begin
            m_sat_reg  <= |rounded[34:32];
            m_data_reg <= (|rounded[34:32]) ? 32'hFFFF_FFFF : rounded[31:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule

// ===== sv/gmpd_checker.sv =====
// Port-level assertions for the mixture block, bound to the top level.
module gmpd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tuser,
    input logic         cfg_wr_en,
    input logic [3:0]   cfg_wr_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // clamp flag means all ones
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
        else $error("saturated result not at maximum");

    // evaluate occupies the block
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == gmpd_pkg::OP_PDF || s_tuser == gmpd_pkg::OP_CDF)
        |=> !s_tready)
        else $error("ready right after evaluate");

    // no result in the cycle after any transaction
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

endmodule

bind gaussian_mixture_pdf_cdf gmpd_checker u_gmpd_checker (.*);
